/* hw/rtl/eads_pkg.sv */
// shared types, constants and helpers of the edge-aware depth smoother
`timescale 1ns / 1ps

package eads_pkg;

	// field and register widths
	localparam int DEPTH_W       = 16;
	localparam int CFG_W         = 11;
	localparam int ADDR_W        = 3;
	localparam int APB_W         = 32;
	localparam int YW            = 11;
	localparam int ROW_W         = 10;
	localparam int SUM_W         = DEPTH_W + 3;

	// line store shape
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int STORED_ROWS   = 4;
	localparam int LANE_W        = 2;
	localparam int WORD_W        = STORED_ROWS * DEPTH_W;

	// frame size limits
	localparam int MIN_SIZE      = 8;
	localparam int HEIGHT_MAX    = 1024;
	localparam int FW_RESET      = 640;
	localparam int FH_RESET      = 480;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_e;

	// input item kind
	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_e;

	// how a 5-tap window is reduced
	typedef enum logic [1:0] {
		TAP_ZERO   = 2'd0,
		TAP_PASS   = 2'd1,
		TAP_SMOOTH = 2'd2
	} tap_mode_e;

	// chosen center, near and far taps; result is (4c+3n+f)/8
	typedef struct packed {
		logic [DEPTH_W-1:0] c;
		logic [DEPTH_W-1:0] n;
		logic [DEPTH_W-1:0] f;
	} tap_sel_t;

	// write-back request of the line store
	typedef struct packed {
		logic               en;
		logic [LANE_W-1:0]  lane;
		logic [DEPTH_W-1:0] data;
	} mem_wr_t;

	// weighted sum of the chosen taps, rounded down
	function automatic logic [DEPTH_W-1:0] tap_sum(input tap_sel_t t);
		logic [SUM_W-1:0] s;
		s = SUM_W'({t.c, 2'b00}) + SUM_W'({t.n, 1'b0}) + SUM_W'(t.n) + SUM_W'(t.f);
		return s[SUM_W-1:3];
	endfunction

endpackage

/* hw/rtl/eads_line_mem.sv */
// line store: four raw rows per column in one word, read-modify-write
`timescale 1ns / 1ps

module eads_line_mem #(
	parameter int MAX_WIDTH = eads_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	input  logic [AW-1:0]                wr_addr,
	input  eads_pkg::mem_wr_t            wr,
	output logic [eads_pkg::WORD_W-1:0]  rd_data
);

	logic [eads_pkg::WORD_W-1:0] mem_q [MAX_WIDTH];
	logic [eads_pkg::WORD_W-1:0] rd_data_q;
	logic [eads_pkg::WORD_W-1:0] merged;

	// replace one row lane of the word read for the same column
	always_comb begin
		merged = rd_data_q;
		merged[eads_pkg::DEPTH_W * wr.lane +: eads_pkg::DEPTH_W] = wr.data;
	end

	// one read and one write port, registered read data held while idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
		if (wr.en) begin
			mem_q[wr_addr] <= merged;
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/eads_tap_select.sv */
// edge-aware choice of the taps for one 5-tap window
`timescale 1ns / 1ps

module eads_tap_select (
	input  eads_pkg::tap_mode_e              mode,
	input  logic [eads_pkg::DEPTH_W-1:0]     a,
	input  logic [eads_pkg::DEPTH_W-1:0]     b,
	input  logic [eads_pkg::DEPTH_W-1:0]     c,
	input  logic [eads_pkg::DEPTH_W-1:0]     d,
	input  logic [eads_pkg::DEPTH_W-1:0]     e,
	output eads_pkg::tap_sel_t               sel
);

	logic                          lo_bad;
	logic                          hi_bad;
	logic                          use_hi;
	logic [eads_pkg::DEPTH_W-1:0]  da;
	logic [eads_pkg::DEPTH_W-1:0]  de;

	// distance of each far tap to the center, which side holds a zero tap, and the side chosen
	always_comb begin
		da     = (a > c) ? a - c : c - a;
		de     = (e > c) ? e - c : c - e;
		lo_bad = (a == '0) || (b == '0);
		hi_bad = (d == '0) || (e == '0);
		priority if (lo_bad) begin
			use_hi = 1'b1;
		end else if (hi_bad) begin
			use_hi = 1'b0;
		end else begin
			use_hi = de < da;
		end
	end

	// taps handed to the weighted sum
	always_comb begin
		unique case (mode)
			eads_pkg::TAP_PASS: begin
				sel = '{c: c, n: c, f: c};
			end
			eads_pkg::TAP_SMOOTH: begin
				if (lo_bad && hi_bad) begin
					sel = '0;
				end else if (use_hi) begin
					sel = '{c: c, n: d, f: e};
				end else begin
					sel = '{c: c, n: b, f: a};
				end
			end
			default: begin
				sel = '0;
			end
		endcase
	end

endmodule

/* hw/rtl/edge_aware_separable_depth_smooth.sv */
// top level: counters, config registers, vertical and horizontal smoothing pipeline
`timescale 1ns / 1ps

// Edge-aware separable depth smoother. Takes one raster pixel or flush item per
// clock and keeps one item per clock when the output side does not stall. A
// pixel's result leaves 2W+2 items after the pixel itself (W = used frame width),
// plus its passage through the pipeline stages and the output register; after the
// last pixel of a frame, 2W+2 further items (flush or pixel, whose depth is dropped) drain the frame.
// The rate is set by the line store: the four stored rows of a column sit in
// one word, so each item costs one read and one write-back of a single word.
// Flush items before the frame is complete are taken and do nothing. Frame
// width and height are taken saturated to [8, MAX_WIDTH] and [8, 1024]; a
// register write restarts the frame and must come while the block is idle.
// The line store needs no clearing after reset.
module edge_aware_separable_depth_smooth #(
	parameter int MAX_WIDTH = eads_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [eads_pkg::ADDR_W-1:0]    paddr,
	input  logic [eads_pkg::APB_W-1:0]     pwdata,
	output logic [eads_pkg::APB_W-1:0]     prdata,
	output logic                           pready,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [eads_pkg::DEPTH_W-1:0]   s_tdata,   // [15:0] pixel_depth
	input  logic                           s_tuser,   // [0] cmd
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [eads_pkg::DEPTH_W-1:0]   m_tdata,   // [15:0] smoothed_depth
	output logic                           m_tlast
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = WW + 1;
	localparam int CW = (WW > eads_pkg::CFG_W) ? WW : eads_pkg::CFG_W;
	localparam int YW = eads_pkg::YW;
	localparam int DW = eads_pkg::DEPTH_W;

	// configuration
	logic [eads_pkg::CFG_W-1:0] frame_width_q;
	logic [eads_pkg::CFG_W-1:0] frame_height_q;
	logic                       cfg_wr;
	eads_pkg::reg_idx_e         reg_idx;
	logic [CW-1:0]              fw_ext;
	logic [WW-1:0]              w_use;
	logic [YW-1:0]              h_use;

	// input position and output position
	logic [XW-1:0]                 x_q;
	logic [YW-1:0]                 y_q;
	logic [XW-1:0]                 ocol_q;
	logic [eads_pkg::ROW_W-1:0]    orow_q;

	// stage 0 decode
	logic                  en;
	logic                  acc;
	logic                  act;
	logic                  real_pix;
	logic                  in_push;
	logic                  in_zero;
	logic                  vsm;
	eads_pkg::tap_mode_e   vmode;
	logic                  emit;
	logic                  hsm;
	logic                  fend;
	logic                  x_last;
	logic                  o_last;

	// stage 1
	logic                          v_s1;
	logic                          push_s1;
	logic                          wr_s1;
	logic                          emit_s1;
	logic                          fend_s1;
	eads_pkg::tap_mode_e           vmode_s1;
	eads_pkg::tap_mode_e           hmode_s1;
	logic [eads_pkg::LANE_W-1:0]   lane_s1;
	logic [DW-1:0]                 pix_s1;
	logic [XW-1:0]                 x_s1;

	// stage 2
	logic                  v_s2;
	logic                  push_s2;
	logic                  emit_s2;
	logic                  fend_s2;
	eads_pkg::tap_mode_e   hmode_s2;
	eads_pkg::tap_sel_t    vsel_s2;

	// stage 3
	logic                  v_s3;
	logic                  fend_s3;
	eads_pkg::tap_mode_e   hmode_s3;

	// stage 4
	logic                  v_s4;
	logic                  fend_s4;
	eads_pkg::tap_sel_t    hsel_s4;

	// output register
	logic                  m_tvalid_q;
	logic [DW-1:0]         m_tdata_q;
	logic                  m_tlast_q;

	// line store and window
	eads_pkg::mem_wr_t              mem_wr;
	logic [eads_pkg::WORD_W-1:0]    rd_word;
	logic [eads_pkg::LANE_W-1:0]    l1;
	logic [eads_pkg::LANE_W-1:0]    l2;
	logic [eads_pkg::LANE_W-1:0]    l3;
	eads_pkg::tap_sel_t             vsel;
	eads_pkg::tap_sel_t             hsel;
	logic [DW-1:0]                  vres;
	logic [DW-1:0]                  win_q [5];

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = eads_pkg::reg_idx_e'(paddr[2]);

	always_comb begin
		unique case (reg_idx)
			eads_pkg::REG_FRAME_WIDTH:  prdata = eads_pkg::APB_W'(frame_width_q);
			eads_pkg::REG_FRAME_HEIGHT: prdata = eads_pkg::APB_W'(frame_height_q);
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= eads_pkg::CFG_W'(eads_pkg::FW_RESET);
			frame_height_q <= eads_pkg::CFG_W'(eads_pkg::FH_RESET);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				eads_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[eads_pkg::CFG_W-1:0];
				eads_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[eads_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// saturated frame size
	always_comb begin
		fw_ext = CW'(frame_width_q);
		if (fw_ext < CW'(eads_pkg::MIN_SIZE)) begin
			w_use = WW'(eads_pkg::MIN_SIZE);
		end else if (fw_ext > CW'(MAX_WIDTH)) begin
			w_use = WW'(MAX_WIDTH);
		end else begin
			w_use = WW'(fw_ext);
		end
		if (frame_height_q < YW'(eads_pkg::MIN_SIZE)) begin
			h_use = YW'(eads_pkg::MIN_SIZE);
		end else if (frame_height_q > YW'(eads_pkg::HEIGHT_MAX)) begin
			h_use = YW'(eads_pkg::HEIGHT_MAX);
		end else begin
			h_use = frame_height_q;
		end
	end

	// handshake: the whole pipeline moves when the output register can take a transfer
	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;
	assign acc      = s_tvalid && s_tready;

	// stage 0 decode from the input and output positions
	always_comb begin
		real_pix = y_q < h_use;
		act      = acc && !(real_pix && (s_tuser == eads_pkg::CMD_FLUSH));
		in_push  = (y_q >= YW'(2)) && (y_q <= h_use + YW'(1));
		in_zero  = y_q >= h_use + YW'(2);
		vsm      = real_pix && (y_q >= YW'(6)) && (y_q + YW'(3) <= h_use);
		if (vsm) begin
			vmode = eads_pkg::TAP_SMOOTH;
		end else if (in_push) begin
			vmode = eads_pkg::TAP_PASS;
		end else begin
			vmode = eads_pkg::TAP_ZERO;
		end
		emit   = (y_q > YW'(2)) || ((y_q == YW'(2)) && (x_q >= XW'(2)));
		x_last = (WW'(x_q) + WW'(1)) == w_use;
		o_last = (WW'(ocol_q) + WW'(1)) == w_use;
		hsm    = (ocol_q >= XW'(4)) && (PW'(ocol_q) + PW'(5) <= PW'(w_use));
		fend   = o_last && ((YW'(orow_q) + YW'(1)) == h_use);
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cfg_wr || (act && emit && fend)) begin
			x_q    <= '0;
			y_q    <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (act) begin
			if (x_last) begin
				x_q <= '0;
				y_q <= y_q + YW'(1);
			end else begin
				x_q <= x_q + XW'(1);
			end
			if (emit) begin
				if (o_last) begin
					ocol_q <= '0;
					orow_q <= orow_q + eads_pkg::ROW_W'(1);
				end else begin
					ocol_q <= ocol_q + XW'(1);
				end
			end
		end
	end

	// line store: read column x at accept, write the new pixel back from stage 1 when the pipeline moves
	assign mem_wr.en   = en && v_s1 && wr_s1;
	assign mem_wr.lane = lane_s1;
	assign mem_wr.data = pix_s1;

	eads_line_mem #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (act),
		.rd_addr (x_q),
		.wr_addr (x_s1),
		.wr      (mem_wr),
		.rd_data (rd_word)
	);

	// pipeline valid bits and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			v_s1       <= act;
			v_s2       <= v_s1;
			v_s3       <= v_s2 && emit_s2;
			v_s4       <= v_s3;
			m_tvalid_q <= v_s4;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			push_s1  <= in_push || in_zero;
			wr_s1    <= real_pix;
			emit_s1  <= emit;
			fend_s1  <= fend;
			vmode_s1 <= vmode;
			hmode_s1 <= hsm ? eads_pkg::TAP_SMOOTH : eads_pkg::TAP_PASS;
			lane_s1  <= y_q[eads_pkg::LANE_W-1:0];
			pix_s1   <= s_tdata;
			x_s1     <= x_q;

			push_s2  <= push_s1;
			emit_s2  <= emit_s1;
			fend_s2  <= fend_s1;
			hmode_s2 <= hmode_s1;
			vsel_s2  <= vsel;

			fend_s3  <= fend_s2;
			hmode_s3 <= hmode_s2;

			fend_s4  <= fend_s3;
			hsel_s4  <= hsel;

			if (v_s4) begin
				m_tdata_q <= eads_pkg::tap_sum(hsel_s4);
				m_tlast_q <= fend_s4;
			end
		end
	end

	// stage 1: vertical taps are rows y-4 .. y-1 of this column and the new pixel
	assign l1 = lane_s1 + eads_pkg::LANE_W'(1);
	assign l2 = lane_s1 + eads_pkg::LANE_W'(2);
	assign l3 = lane_s1 + eads_pkg::LANE_W'(3);

	eads_tap_select u_vsel (
		.mode (vmode_s1),
		.a    (rd_word[DW * lane_s1 +: DW]),
		.b    (rd_word[DW * l1 +: DW]),
		.c    (rd_word[DW * l2 +: DW]),
		.d    (rd_word[DW * l3 +: DW]),
		.e    (pix_s1),
		.sel  (vsel)
	);

	// stage 2: vertical result into the horizontal window
	assign vres = eads_pkg::tap_sum(vsel_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				win_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			for (int i = 0; i < 5; i++) begin
				win_q[i] <= '0;
			end
		end else if (en && v_s2 && push_s2) begin
			for (int i = 0; i < 4; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[4] <= vres;
		end
	end

	// stage 3: horizontal tap choice over the window
	eads_tap_select u_hsel (
		.mode (hmode_s3),
		.a    (win_q[0]),
		.b    (win_q[1]),
		.c    (win_q[2]),
		.d    (win_q[3]),
		.e    (win_q[4]),
		.sel  (hsel)
	);

	// output register
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// the write-back never lands on the column being read in the same cycle
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(act && mem_wr.en) |-> (x_q != x_s1))
		else $error("line store read and write-back hit the same column");

	// input column stays inside the used width
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(x_q) < w_use)
		else $error("input column beyond frame width");

	// input row runs at most two rows past the frame while draining
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		y_q <= h_use + YW'(2))
		else $error("input row beyond drain range");

	// a frame end result leaves the output positions and the input row cleared behind it
	a_fend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(act && emit && fend && !cfg_wr) |=> (ocol_q == '0) && (orow_q == '0) && (y_q == '0))
		else $error("counters not cleared after last pixel of frame");

endmodule

/* dv/depth_smooth_checker.sv */
// checker: follows register writes and stream transfers, predicts smoothed depth, compares
`timescale 1ns / 1ps

module depth_smooth_checker
	import eads_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [APB_W-1:0]   pwdata,
	input  logic [APB_W-1:0]   prdata,
	input  logic               pready,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [DEPTH_W-1:0] s_tdata,   // [15:0] pixel_depth
	input  logic               s_tuser,   // [0] cmd
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [DEPTH_W-1:0] m_tdata,   // [15:0] smoothed_depth
	input  logic               m_tlast,
	output int unsigned        fail_count,
	output int unsigned        results_due
);

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic               last;
	} depth_out_t;

	localparam int LINE_SLOTS = STORED_ROWS * MAX_WIDTH_DEF;

	// register copies and frame state of the predictor
	logic [CFG_W-1:0]   width_reg;
	logic [CFG_W-1:0]   height_reg;
	logic [DEPTH_W-1:0] line_rows [LINE_SLOTS];
	logic [DEPTH_W-1:0] vert_win [5];
	int unsigned        in_col;
	int unsigned        in_row;
	int unsigned        out_col;
	int unsigned        out_row;
	depth_out_t         depth_due_q [$];
	depth_out_t         oldest;
	logic [APB_W-1:0]   reg_value;

	function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned hi);
		if (v < MIN_SIZE) return MIN_SIZE;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned line_slot(input int unsigned row, input int unsigned col);
		return (row % STORED_ROWS) * MAX_WIDTH_DEF + (col % MAX_WIDTH_DEF);
	endfunction

	// 5-tap edge-aware rule, a/b upper or left side, d/e lower or right side
	function automatic logic [DEPTH_W-1:0] edge_pick(input logic [DEPTH_W-1:0] a,
			input logic [DEPTH_W-1:0] b, input logic [DEPTH_W-1:0] c,
			input logic [DEPTH_W-1:0] d, input logic [DEPTH_W-1:0] e);
		logic        lo_bad;
		logic        hi_bad;
		logic        take_hi;
		int unsigned da;
		int unsigned de;
		int unsigned s;
		lo_bad = (a == 0) || (b == 0);
		hi_bad = (d == 0) || (e == 0);
		if (lo_bad && hi_bad) return '0;
		if (lo_bad) begin
			take_hi = 1'b1;
		end else if (hi_bad) begin
			take_hi = 1'b0;
		end else begin
			da = (a > c) ? a - c : c - a;
			de = (e > c) ? e - c : c - e;
			// ties stay on the upper or left side
			take_hi = de < da;
		end
		if (take_hi) s = 4 * c + 3 * d + e;
		else s = 4 * c + 3 * b + a;
		return s[DEPTH_W+2:3];
	endfunction

	task automatic clear_frame_state();
		for (int i = 0; i < 5; i++) vert_win[i] = '0;
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endtask

	task automatic shift_window(input logic [DEPTH_W-1:0] v);
		for (int i = 0; i < 4; i++) vert_win[i] = vert_win[i+1];
		vert_win[4] = v;
	endtask

	// one accepted item: vertical pass, line store update, horizontal pass
	task automatic smooth_depth_item(input cmd_e kind, input logic [DEPTH_W-1:0] depth);
		int unsigned        w;
		int unsigned        h;
		int unsigned        x;
		int unsigned        y;
		int unsigned        r;
		logic               in_frame;
		logic               emit;
		logic [DEPTH_W-1:0] v;
		depth_out_t         res;
		w = clamp_size(width_reg, MAX_WIDTH_DEF);
		h = clamp_size(height_reg, HEIGHT_MAX);
		x = in_col;
		y = in_row;
		in_frame = y < h;
		// flush before the frame is complete does nothing
		if (in_frame && kind == CMD_FLUSH) return;
		if (y >= 2 && y <= h + 1) begin
			r = y - 2;
			if (in_frame && r >= 4 && r + 5 <= h) begin
				v = edge_pick(line_rows[line_slot(y - 4, x)], line_rows[line_slot(y - 3, x)],
					line_rows[line_slot(y - 2, x)], line_rows[line_slot(y - 1, x)], depth);
			end else begin
				v = line_rows[line_slot(r, x)];
			end
			shift_window(v);
		end else if (y >= h + 2) begin
			shift_window('0);
		end
		// while draining, pixel depth is dropped
		if (in_frame) line_rows[line_slot(y, x)] = depth;
		emit = (y > 2) || (y == 2 && x >= 2);
		x++;
		if (x >= w) begin
			x = 0;
			y++;
		end
		in_col = x;
		in_row = y;
		if (!emit) return;
		if (out_col >= 4 && out_col + 5 <= w) begin
			res.depth = edge_pick(vert_win[0], vert_win[1], vert_win[2], vert_win[3], vert_win[4]);
		end else begin
			res.depth = vert_win[2];
		end
		res.last = (out_col + 1 == w) && (out_row + 1 == h);
		depth_due_q.push_back(res);
		if (res.last) begin
			clear_frame_state();
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [APB_W-1:0] got,
			input logic [APB_W-1:0] want);
		$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = CFG_W'(FW_RESET);
			height_reg = CFG_W'(FH_RESET);
			clear_frame_state();
			depth_due_q.delete();
			fail_count = 0;
			results_due <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_FRAME_WIDTH) width_reg = pwdata[CFG_W-1:0];
					else height_reg = pwdata[CFG_W-1:0];
					// any write restarts the frame
					clear_frame_state();
				end else begin
					reg_value = (paddr[2] == REG_FRAME_WIDTH) ? APB_W'(width_reg) : APB_W'(height_reg);
					if (prdata !== reg_value) report_mismatch("register readback", prdata, reg_value);
				end
			end
			if (s_tvalid && s_tready) smooth_depth_item(cmd_e'(s_tuser), s_tdata);
			if (m_tvalid && m_tready) begin
				if (depth_due_q.size() == 0) begin
					report_mismatch("output transfer with nothing due", APB_W'(m_tdata), '0);
				end else begin
					oldest = depth_due_q.pop_front();
					if (m_tdata !== oldest.depth)
						report_mismatch("smoothed_depth", APB_W'(m_tdata), APB_W'(oldest.depth));
					if (m_tlast !== oldest.last)
						report_mismatch("frame_end", APB_W'(m_tlast), APB_W'(oldest.last));
				end
			end
			results_due <= depth_due_q.size();
		end
	end

endmodule

/* dv/tb_top.sv */
// testbench top: clock, reset, register setup, depth frame stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
	import eads_pkg::*;

	localparam int          CLK_HALF      = 10;
	localparam int          RESET_CYCLES  = 6;
	localparam int          ITEM_GOAL     = 1350;
	localparam int          SETTLE_CYCLES = 32;
	localparam int          HOLD_CYCLES   = 1500;
	localparam int unsigned CYCLE_LIMIT   = 3_000_000;

	typedef enum int {DS_FLAT, DS_NOISE, DS_EXTREME, DS_STEP} depth_style_e;
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKED, RX_CADENCE} rx_mode_e;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [APB_W-1:0]   pwdata;
	logic [APB_W-1:0]   prdata;
	logic               pready;
	logic               s_tvalid;
	logic               s_tready;
	logic [DEPTH_W-1:0] s_tdata;   // [15:0] pixel_depth
	logic               s_tuser;   // [0] cmd
	logic               m_tvalid;
	logic               m_tready;
	logic [DEPTH_W-1:0] m_tdata;   // [15:0] smoothed_depth
	logic               m_tlast;

	int unsigned fail_count;
	int unsigned results_due;
	int unsigned size_w = FW_RESET;
	int unsigned size_h = FH_RESET;
	int          random_items = 0;
	int          burst_left = 0;
	int          hold_asks = 0;
	int          hold_done = 0;
	logic        offering = 1'b0;
	logic        frame_open = 1'b0;

	always #(CLK_HALF) clk = ~clk;

	edge_aware_separable_depth_smooth i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	depth_smooth_checker i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	function automatic int unsigned frame_dim(input int unsigned v, input int unsigned lim);
		if (v < MIN_SIZE) return MIN_SIZE;
		return (v > lim) ? lim : v;
	endfunction

	// depth samples: flat surfaces, noise, extremes and steps, with holes
	function automatic logic [DEPTH_W-1:0] gen_depth(input depth_style_e style,
			input logic [DEPTH_W-1:0] base);
		case (style)
			DS_FLAT: begin
				if ($urandom_range(0, 7) == 0) return '0;
				return base + DEPTH_W'($urandom_range(0, 3));
			end
			DS_NOISE: begin
				if ($urandom_range(0, 3) == 0) return '0;
				return DEPTH_W'($urandom);
			end
			DS_EXTREME: begin
				case ($urandom_range(0, 5))
					0: return 16'h0000;
					1: return 16'h0001;
					2: return 16'hFFFF;
					3: return 16'hFFFE;
					4: return 16'h8000;
					default: return 16'h7FFF;
				endcase
			end
			default: begin
				if ($urandom_range(0, 15) == 0) return '0;
				return $urandom_range(0, 1) ? base : base ^ 16'h5A5A;
			end
		endcase
	endfunction

	// one register access, setup then access phase
	task automatic apb_access(input logic wr, input reg_idx_e idx, input int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= APB_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// offer one item, then maybe a gap when the burst runs out
	task automatic send_item(input cmd_e kind, input logic [DEPTH_W-1:0] depth);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= depth;
		offering = 1'b1;
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(0, 63);
			gap = $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			offering = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic stop_stream();
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// no input offered, all results in, pipeline settled
	task automatic wait_idle();
		stop_stream();
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reconfigure(input int unsigned w, input int unsigned h);
		wait_idle();
		apb_access(1'b1, REG_FRAME_WIDTH, w);
		apb_access(1'b1, REG_FRAME_HEIGHT, h);
		apb_access(1'b0, REG_FRAME_WIDTH, 0);
		apb_access(1'b0, REG_FRAME_HEIGHT, 0);
		size_w = w & 11'h7FF;
		size_h = h & 11'h7FF;
		frame_open = 1'b0;
	endtask

	// one frame plus its drain, from position skip, abandoned at item cut if cut >= 0
	task automatic run_frame(input depth_style_e style, input int skip, input int cut);
		int                 w;
		int                 h;
		int                 npix;
		int                 total;
		int                 k;
		logic [DEPTH_W-1:0] base;
		w = frame_dim(size_w, MAX_WIDTH_DEF);
		h = frame_dim(size_h, HEIGHT_MAX);
		npix = w * h;
		total = npix + 2 * w + 2;
		base = DEPTH_W'($urandom);
		for (k = skip; k < total; k++) begin
			if (k == cut) break;
			if (k < npix) begin
				// flush inside an incomplete frame is ignored
				if ($urandom_range(0, 15) == 0) send_item(CMD_FLUSH, DEPTH_W'($urandom));
				if ($urandom_range(0, 39) == 0) base = DEPTH_W'($urandom);
				send_item(CMD_PIXEL, gen_depth(style, base));
			end else if ($urandom_range(0, 2) == 0) begin
				// pixel while draining acts as flush
				send_item(CMD_PIXEL, DEPTH_W'($urandom));
			end else begin
				send_item(CMD_FLUSH, DEPTH_W'($urandom));
			end
			random_items++;
		end
		frame_open = k < total;
	endtask

	// output side stall patterns and long hold-offs on request
	initial begin
		int       span;
		rx_mode_e mode;
		span = 0;
		mode = RX_OPEN;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_done) begin
				m_tready <= 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
				hold_done++;
			end else begin
				if (span == 0) begin
					mode = rx_mode_e'($urandom_range(0, 4));
					span = $urandom_range(16, 400);
				end
				span--;
				case (mode)
					RX_OPEN:    m_tready <= 1'b1;
					RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE:  m_tready <= ($urandom_range(0, 7) != 0);
					RX_CHOKED:  m_tready <= ($urandom_range(0, 3) == 0);
					default:    m_tready <= (span % 5 != 0);
				endcase
			end
		end
	end

	// run time limit
	initial begin
		int unsigned cycles_run;
		cycles_run = 0;
		while (cycles_run < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// stimulus
	initial begin
		int                 phase;
		int                 cut;
		int unsigned        w_pick;
		int unsigned        h_pick;
		logic [DEPTH_W-1:0] opening [18];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset values, flush with nothing pending, field extremes
		apb_access(1'b0, REG_FRAME_WIDTH, 0);
		apb_access(1'b0, REG_FRAME_HEIGHT, 0);
		send_item(CMD_FLUSH, 16'hFFFF);
		reconfigure(12, 10);
		opening = '{16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF,
			16'h0000, 16'hFFFE, 16'h0100, 16'h0100, 16'h0104, 16'h0000,
			16'h00FF, 16'hFF00, 16'h0000, 16'h0000, 16'hFFFF, 16'h5555};
		for (int i = 0; i < 18; i++) begin
			if (i == 5) send_item(CMD_FLUSH, 16'h0000);
			send_item(CMD_PIXEL, opening[i]);
		end
		run_frame(DS_FLAT, 18, -1);
		// next frame starts right after the last result, no register write
		run_frame(DS_STEP, 0, -1);

		// random frames of small sizes, some abandoned, some back to back
		phase = 0;
		while (random_items < ITEM_GOAL) begin
			if (frame_open || $urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 6))
					0:       w_pick = $urandom_range(0, 8);
					1:       w_pick = $urandom_range(25, 64);
					default: w_pick = $urandom_range(9, 24);
				endcase
				h_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(9, 14);
				reconfigure(w_pick, h_pick);
			end
			if (phase == 2) hold_asks <= hold_asks + 1;
			cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 150) : -1;
			run_frame(depth_style_e'($urandom_range(0, 3)), 0, cut);
			phase++;
		end

		// size extremes, out-of-range values saturate
		reconfigure(0, 3);
		run_frame(DS_EXTREME, 0, -1);
		reconfigure(1024, 8);
		run_frame(DS_FLAT, 0, -1);
		reconfigure(2047, 8);
		run_frame(DS_NOISE, 0, 3000);
		reconfigure(8, 1024);
		hold_asks <= hold_asks + 1;
		run_frame(DS_STEP, 0, -1);
		reconfigure(5, 2047);
		run_frame(DS_FLAT, 0, 600);

		wait_idle();
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
